/* rtl/pca_pkg.sv */
// ----------------------------------------------------------------------------
// pca_pkg: shared types and constants of the pixel color adjust block
// Beat layouts, register map, image class codes and fixed-point constants.
// ----------------------------------------------------------------------------
package pca_pkg;

  // Gains are Q4.12.
  localparam int GAIN_BITS = 12;
  localparam logic [15:0] GAIN_UNITY = 16'd4096;

  // floor(y / 255) = (y * RECIP_255) >> RECIP_SHIFT, exact for any 32-bit y.
  localparam logic [31:0] RECIP_255 = 32'h8080_8081;
  localparam int RECIP_SHIFT = 39;

  // Rec.709 luma weights in units of 2^-16.
  localparam logic [15:0] LUMA_R = 16'd13926;
  localparam logic [15:0] LUMA_G = 16'd46884;
  localparam logic [15:0] LUMA_B = 16'd4725;
  localparam int LUMA_SHIFT = 16;

  // floor(s / 3) = (s * RECIP_3) >> RECIP_3_SHIFT, exact for s up to 765.
  localparam logic [9:0] RECIP_3 = 10'd683;
  localparam int RECIP_3_SHIFT = 11;

  localparam logic [1:0] CLASS_WORLD    = 2'd1;
  localparam logic [1:0] CLASS_LIGHTMAP = 2'd2;

  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_LIGHTMAP   = 3'd1;
  localparam logic [2:0] REG_CONTRAST   = 3'd2;
  localparam logic [2:0] REG_SATURATION = 3'd3;
  localparam logic [2:0] REG_MONOCHROME = 3'd4;
  localparam logic [2:0] REG_INVERT     = 3'd5;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic [1:0] image_class;
    logic       last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_pixel_out;
  } pixel_out_t;

  // Fields that ride along the pipeline untouched.
  typedef struct packed {
    logic [1:0] image_class;
    logic [7:0] alpha;
    logic       last_pixel;
  } side_t;

  typedef struct packed {
    logic [15:0] brightness_gain;
    logic [15:0] lightmap_gain;
    logic [15:0] contrast_gain;
    logic [15:0] saturation_mix;
    logic [1:0]  monochrome_select;
    logic [1:0]  invert_select;
  } cfg_t;

endpackage

/* rtl/pca_scale.sv */
// ----------------------------------------------------------------------------
// pca_scale: gain scaling front end
// Scales each channel byte by its class gain into a fraction with
// FRACTION_BITS fraction bits and finds the largest channel. Four stages.
// ----------------------------------------------------------------------------
module pca_scale #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid_in,
  input  pca_pkg::pixel_in_t                  pixel,
  input  pca_pkg::cfg_t                       cfg,
  output logic                                valid_out,
  output pca_pkg::side_t                      side_out,
  output logic [2:0][FRACTION_BITS+3:0]       t_out,
  output logic [FRACTION_BITS+3:0]            max_out,
  output logic                                clip_out
);
  import pca_pkg::*;

  localparam int TW = FRACTION_BITS + 4;
  localparam logic [TW-1:0] ONE = TW'(1) << FRACTION_BITS;

  logic [2:0][7:0]  chan;
  logic [15:0]      gain;
  logic [2:0][23:0] p1;
  logic [2:0][23:0] p2;
  logic [2:0][15:0] q2;
  logic [2:0][TW-1:0] t3;
  logic [55:0]      qprod [3];
  logic [63:0]      xprod [3];
  logic [23:0]      q255 [3];
  logic [23:0]      rem24 [3];
  logic [31:0]      yscaled [3];
  logic [FRACTION_BITS+15:0] full [3];
  logic [TW-1:0]    m01;
  logic [TW-1:0]    mx;
  logic [3:0]       vld;
  side_t            sd [4];

  always_comb begin
    chan[0] = pixel.red_in;
    chan[1] = pixel.green_in;
    chan[2] = pixel.blue_in;
    gain = (pixel.image_class == CLASS_LIGHTMAP) ? cfg.lightmap_gain : cfg.brightness_gain;
  end

  // The product c * gain is split as 255 * q + r. Then
  // floor(c * gain * 2^F / 255) = q * 2^F + floor(r * 2^F / 255), and the
  // second term is below 2^F, so the two simply concatenate.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qprod[j]   = {32'b0, p1[j]} * {24'b0, RECIP_255};
      q255[j]    = {q2[j], 8'b0} - {8'b0, q2[j]};
      rem24[j]   = p2[j] - q255[j];
      yscaled[j] = 32'(rem24[j][7:0]) << FRACTION_BITS;
      xprod[j]   = {32'b0, yscaled[j]} * {32'b0, RECIP_255};
      full[j]    = {q2[j], xprod[j][RECIP_SHIFT+FRACTION_BITS-1:RECIP_SHIFT]};
    end
    m01 = (t3[0] > t3[1]) ? t3[0] : t3[1];
    mx  = (m01 > t3[2]) ? m01 : t3[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], valid_in};
    end
    sd[0] <= '{image_class: pixel.image_class, alpha: pixel.alpha_in,
               last_pixel: pixel.last_pixel};
    sd[1] <= sd[0];
    sd[2] <= sd[1];
    sd[3] <= sd[2];
    for (int j = 0; j < 3; j++) begin
      p1[j]    <= {16'b0, chan[j]} * {8'b0, gain};
      p2[j]    <= p1[j];
      q2[j]    <= qprod[j][RECIP_SHIFT+15:RECIP_SHIFT];
      t3[j]    <= full[j][FRACTION_BITS+15:GAIN_BITS];
      t_out[j] <= t3[j];
    end
    max_out  <= mx;
    clip_out <= (mx > ONE);
  end

  assign valid_out = vld[3];
  assign side_out  = sd[3];

endmodule

/* rtl/pca_hue_div.sv */
// ----------------------------------------------------------------------------
// pca_hue_div: hue-preserving clip divider
// Restoring division t * 2^F / max for all three channels, one quotient bit
// per stage over FRACTION_BITS + 1 stages. Unclipped pixels keep their value.
// ----------------------------------------------------------------------------
module pca_hue_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  input  pca_pkg::side_t                side_in,
  input  logic [2:0][FRACTION_BITS+3:0] t_in,
  input  logic [FRACTION_BITS+3:0]      max_in,
  input  logic                          clip_in,
  output logic                          valid_out,
  output pca_pkg::side_t                side_out,
  output logic [2:0][FRACTION_BITS:0]   t_out
);
  import pca_pkg::*;

  localparam int TW = FRACTION_BITS + 4;
  localparam int NS = FRACTION_BITS + 1;

  logic               vld  [NS];
  side_t              sd   [NS];
  logic [2:0][TW-1:0] rem  [NS];
  logic [2:0][NS-1:0] quo  [NS];
  logic [2:0][NS-1:0] keep [NS];
  logic [TW-1:0]      dvs  [NS];
  logic               clp  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic               vld_prev;
    side_t              sd_prev;
    logic [2:0][NS-1:0] keep_prev;
    logic [TW-1:0]      dvs_prev;
    logic               clp_prev;
    logic [2:0][NS-1:0] quo_prev;
    logic [2:0][TW:0]   cand;
    logic [2:0]         ge;

    if (k == 0) begin : g_first
      // The first stage yields the integer bit, which is at most one since
      // no channel exceeds the maximum.
      always_comb begin
        vld_prev = valid_in;
        sd_prev  = side_in;
        dvs_prev = max_in;
        clp_prev = clip_in;
        quo_prev = '0;
        for (int j = 0; j < 3; j++) begin
          keep_prev[j] = t_in[j][NS-1:0];
          cand[j]      = {1'b0, t_in[j]};
        end
      end
    end else begin : g_next
      always_comb begin
        vld_prev  = vld[k-1];
        sd_prev   = sd[k-1];
        dvs_prev  = dvs[k-1];
        clp_prev  = clp[k-1];
        quo_prev  = quo[k-1];
        keep_prev = keep[k-1];
        for (int j = 0; j < 3; j++) begin
          cand[j] = {rem[k-1][j], 1'b0};
        end
      end
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        ge[j] = (cand[j] >= {1'b0, dvs_prev});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_prev;
      end
      sd[k]   <= sd_prev;
      dvs[k]  <= dvs_prev;
      clp[k]  <= clp_prev;
      keep[k] <= keep_prev;
      for (int j = 0; j < 3; j++) begin
        rem[k][j] <= ge[j] ? TW'(cand[j] - {1'b0, dvs_prev}) : cand[j][TW-1:0];
        quo[k][j] <= {quo_prev[j][NS-2:0], ge[j]};
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t_out[j] = clp[NS-1] ? quo[NS-1][j] : keep[NS-1][j];
    end
  end

  assign valid_out = vld[NS-1];
  assign side_out  = sd[NS-1];

endmodule

/* rtl/pca_tone.sv */
// ----------------------------------------------------------------------------
// pca_tone: contrast, luma and saturation stages
// Contrast around mid grey with clamping, Rec.709 luma, saturation mix and
// conversion back to bytes. Seven stages.
// ----------------------------------------------------------------------------
module pca_tone #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  pca_pkg::side_t              side_in,
  input  logic [2:0][FRACTION_BITS:0] t_in,
  input  pca_pkg::cfg_t               cfg,
  output logic                        valid_out,
  output pca_pkg::side_t              side_out,
  output logic [2:0][7:0]             byte_out
);
  import pca_pkg::*;

  localparam int TB = FRACTION_BITS + 1;
  localparam int PW = FRACTION_BITS + 19;
  localparam int LW = FRACTION_BITS + 17;
  localparam int UW = PW - GAIN_BITS;
  localparam int BW = PW + 8 - FRACTION_BITS - GAIN_BITS;
  localparam logic [TB-1:0] ONE = TB'(1) << FRACTION_BITS;
  localparam logic signed [TB:0] HALF = (TB+1)'(1) << (FRACTION_BITS - 1);
  localparam logic signed [PW-1:0] MID = PW'(1) << (FRACTION_BITS - 1 + GAIN_BITS);

  logic signed [TB:0]   diff_c [3];
  logic signed [PW-1:0] prod_c [3];
  logic signed [PW-1:0] c1_prod [3];
  logic signed [PW-1:0] v_c [3];
  logic [UW-1:0]        u_c [3];
  logic [TB-1:0]        t_c [3];
  logic [2:0][TB-1:0]   c2_t;
  logic [LW-1:0]        l1_lum [3];
  logic [2:0][TB-1:0]   l1_t;
  logic [LW+1:0]        lsum;
  logic [TB-1:0]        l2_d;
  logic [2:0][TB-1:0]   l2_t;
  logic signed [TB:0]   diff_m [3];
  logic signed [PW-1:0] prod_m [3];
  logic signed [PW-1:0] m1_prod [3];
  logic [TB-1:0]        m1_d;
  logic signed [PW-1:0] m2_w [3];
  logic [PW+7:0]        x255 [3];
  logic [BW-1:0]        bval [3];
  logic [6:0]           vld;
  side_t                sd [7];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff_c[j] = $signed({1'b0, t_in[j]}) - HALF;
      prod_c[j] = PW'(diff_c[j]) * PW'($signed({1'b0, cfg.contrast_gain}));

      // A negative stretched value clamps to zero, a large one to full scale.
      v_c[j] = c1_prod[j] + MID;
      u_c[j] = v_c[j][PW-1:GAIN_BITS];
      if (v_c[j][PW-1]) begin
        t_c[j] = '0;
      end else if (u_c[j] > UW'(ONE)) begin
        t_c[j] = ONE;
      end else begin
        t_c[j] = u_c[j][TB-1:0];
      end

      diff_m[j] = $signed({1'b0, l2_t[j]}) - $signed({1'b0, l2_d});
      prod_m[j] = PW'(diff_m[j]) * PW'($signed({1'b0, cfg.saturation_mix}));

      // Byte conversion: w * 255 as a shift and subtract.
      x255[j] = {m2_w[j], 8'b0} - {8'b0, m2_w[j]};
      bval[j] = x255[j][PW+7:FRACTION_BITS+GAIN_BITS];
    end
    lsum = (LW+2)'(l1_lum[0]) + (LW+2)'(l1_lum[1]) + (LW+2)'(l1_lum[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], valid_in};
    end
    sd[0] <= side_in;
    for (int s = 1; s < 7; s++) begin
      sd[s] <= sd[s-1];
    end

    for (int j = 0; j < 3; j++) begin
      c1_prod[j] <= prod_c[j];
      c2_t[j]    <= t_c[j];
      l1_t[j]    <= c2_t[j];
      l2_t[j]    <= l1_t[j];
      m1_prod[j] <= prod_m[j];
      m2_w[j]    <= m1_prod[j] + $signed(PW'({m1_d, {GAIN_BITS{1'b0}}}));
      if (m2_w[j][PW-1] || (m2_w[j] == '0)) begin
        byte_out[j] <= 8'd0;
      end else if (bval[j] > BW'(8'hFF)) begin
        byte_out[j] <= 8'hFF;
      end else begin
        byte_out[j] <= bval[j][7:0];
      end
    end
    l1_lum[0] <= LW'(c2_t[0]) * LW'(LUMA_R);
    l1_lum[1] <= LW'(c2_t[1]) * LW'(LUMA_G);
    l1_lum[2] <= LW'(c2_t[2]) * LW'(LUMA_B);
    l2_d      <= lsum[LUMA_SHIFT+TB-1:LUMA_SHIFT];
    m1_d      <= l2_d;
  end

  assign valid_out = vld[6];
  assign side_out  = sd[6];

endmodule

/* rtl/pca_post.sv */
// ----------------------------------------------------------------------------
// pca_post: per-class monochrome and inversion
// Replaces the channels by their integer mean and inverts them where the
// image class enables it, and registers the result beat.
// ----------------------------------------------------------------------------
module pca_post (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  pca_pkg::side_t      side_in,
  input  logic [2:0][7:0]     byte_in,
  input  pca_pkg::cfg_t       cfg,
  output logic                done,
  output pca_pkg::pixel_out_t result
);
  import pca_pkg::*;

  logic [9:0]      sum;
  logic [19:0]     mprod;
  logic [7:0]      mean;
  logic            mono_en;
  logic            inv_en;
  logic [2:0][7:0] chan;

  always_comb begin
    sum   = 10'(byte_in[0]) + 10'(byte_in[1]) + 10'(byte_in[2]);
    mprod = {10'b0, sum} * {10'b0, RECIP_3};
    mean  = mprod[RECIP_3_SHIFT+7:RECIP_3_SHIFT];
    mono_en = ((side_in.image_class == CLASS_WORLD) && cfg.monochrome_select[0]) ||
              ((side_in.image_class == CLASS_LIGHTMAP) && cfg.monochrome_select[1]);
    inv_en  = ((side_in.image_class == CLASS_WORLD) && cfg.invert_select[0]) ||
              ((side_in.image_class == CLASS_LIGHTMAP) && cfg.invert_select[1]);
    for (int j = 0; j < 3; j++) begin
      chan[j] = mono_en ? mean : byte_in[j];
      if (inv_en) begin
        chan[j] = ~chan[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_in;
    end
    result <= '{red_out: chan[0], green_out: chan[1], blue_out: chan[2],
                alpha_out: side_in.alpha, last_pixel_out: side_in.last_pixel};
  end

endmodule

/* rtl/pixel_color_adjust.sv */
// ----------------------------------------------------------------------------
// pixel_color_adjust: per-pixel brightness, contrast and saturation adjust
// Top level with the register port and the processing pipeline.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock at which start is high; busy never rises,
// so the block sustains one pixel per clock. Each result appears on result for
// one cycle with done high. The hue-preserving clip divider resolves one
// quotient bit per stage over FRACTION_BITS + 1 stages; the remaining twelve
// stages hold the gain scaling, contrast, luma, saturation and
// monochrome/inversion steps. Results cannot be held off, so the receiver
// must take every beat as it comes. Registers must be written only while no
// pixel is in flight; the block itself does not enforce this.
module pixel_color_adjust #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pca_pkg::pixel_in_t  pixel,
  output logic                done,
  output pca_pkg::pixel_out_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pca_pkg::*;

  localparam int LATENCY = FRACTION_BITS + 13;

  cfg_t                          cfg;
  logic                          accepted;
  logic                          wr_en;
  logic                          sc_valid;
  side_t                         sc_side;
  logic [2:0][FRACTION_BITS+3:0] sc_t;
  logic [FRACTION_BITS+3:0]      sc_max;
  logic                          sc_clip;
  logic                          dv_valid;
  side_t                         dv_side;
  logic [2:0][FRACTION_BITS:0]   dv_t;
  logic                          tn_valid;
  side_t                         tn_side;
  logic [2:0][7:0]               tn_byte;

  assign busy     = 1'b0;
  assign pready   = 1'b1;
  assign accepted = start && !busy;
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness_gain   <= GAIN_UNITY;
      cfg.lightmap_gain     <= GAIN_UNITY;
      cfg.contrast_gain     <= GAIN_UNITY;
      cfg.saturation_mix    <= GAIN_UNITY;
      cfg.monochrome_select <= 2'b00;
      cfg.invert_select     <= 2'b00;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_BRIGHTNESS: cfg.brightness_gain   <= pwdata[15:0];
        REG_LIGHTMAP:   cfg.lightmap_gain     <= pwdata[15:0];
        REG_CONTRAST:   cfg.contrast_gain     <= pwdata[15:0];
        REG_SATURATION: cfg.saturation_mix    <= pwdata[15:0];
        REG_MONOCHROME: cfg.monochrome_select <= pwdata[1:0];
        REG_INVERT:     cfg.invert_select     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_BRIGHTNESS: prdata = {16'b0, cfg.brightness_gain};
      REG_LIGHTMAP:   prdata = {16'b0, cfg.lightmap_gain};
      REG_CONTRAST:   prdata = {16'b0, cfg.contrast_gain};
      REG_SATURATION: prdata = {16'b0, cfg.saturation_mix};
      REG_MONOCHROME: prdata = {30'b0, cfg.monochrome_select};
      REG_INVERT:     prdata = {30'b0, cfg.invert_select};
      default:        prdata = 32'b0;
    endcase
  end

  pca_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (accepted),
    .pixel     (pixel),
    .cfg       (cfg),
    .valid_out (sc_valid),
    .side_out  (sc_side),
    .t_out     (sc_t),
    .max_out   (sc_max),
    .clip_out  (sc_clip)
  );

  pca_hue_div #(.FRACTION_BITS(FRACTION_BITS)) u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sc_valid),
    .side_in   (sc_side),
    .t_in      (sc_t),
    .max_in    (sc_max),
    .clip_in   (sc_clip),
    .valid_out (dv_valid),
    .side_out  (dv_side),
    .t_out     (dv_t)
  );

  pca_tone #(.FRACTION_BITS(FRACTION_BITS)) u_tone (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (dv_valid),
    .side_in   (dv_side),
    .t_in      (dv_t),
    .cfg       (cfg),
    .valid_out (tn_valid),
    .side_out  (tn_side),
    .byte_out  (tn_byte)
  );

  pca_post u_post (
    .clk      (clk),
    .rst      (rst),
    .valid_in (tn_valid),
    .side_in  (tn_side),
    .byte_in  (tn_byte),
    .cfg      (cfg),
    .done     (done),
    .result   (result)
  );

`ifndef SYNTHESIS
  // Every accepted pixel comes out exactly once, after the full pipe depth.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accepted |-> ##LATENCY done)
    else $error("accepted pixel did not produce a result beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accepted |-> ##LATENCY !done)
    else $error("result beat without an accepted pixel");

  // Alpha and the last-pixel flag stay with their own pixel.
  a_side_aligned: assert property (@(posedge clk) disable iff (rst)
    accepted |-> ##LATENCY ((result.alpha_out == $past(pixel.alpha_in, LATENCY)) &&
                            (result.last_pixel_out == $past(pixel.last_pixel, LATENCY))))
    else $error("alpha or last-pixel flag misaligned with its pixel");

  // A monochrome class always yields three equal channels.
  a_mono_gray: assert property (@(posedge clk) disable iff (rst)
    (done && ((cfg.monochrome_select[0] &&
               ($past(pixel.image_class, LATENCY) == CLASS_WORLD)) ||
              (cfg.monochrome_select[1] &&
               ($past(pixel.image_class, LATENCY) == CLASS_LIGHTMAP))))
    |-> ((result.red_out == result.green_out) && (result.green_out == result.blue_out)))
    else $error("monochrome result has unequal channels");
`endif

endmodule

/* dv/pixel_color_adjust_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_color_adjust_test: self-checking testbench of the pixel color adjust
// Programs the gain, contrast, saturation and class-select registers through
// the register port. It streams directed pixels with fixed gaps, then random
// pixels with random gaps under several settings. A scoreboard predicts every
// adjusted pixel and checks each result beat, field by field, in order.
// ----------------------------------------------------------------------------
module pixel_color_adjust_test;
  import pca_pkg::*;

  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 64;

  localparam logic [1:0] CLASS_OTHER = 2'd0;
  localparam logic [1:0] CLASS_SPARE = 2'd3;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam longint ONE = longint'(1) << FRAC;
  localparam longint HALF = longint'(1) << (FRAC - 1);
  localparam longint GAIN_SCALE = longint'(1) << GAIN_BITS;

  class pixel_scoreboard;
    cfg_t cfg;
    pixel_out_t expected_q[$];
    int errors;

    function new();
      cfg.brightness_gain = 16'd4096;
      cfg.lightmap_gain = 16'd4096;
      cfg.contrast_gain = 16'd4096;
      cfg.saturation_mix = 16'd4096;
      cfg.monochrome_select = 2'd0;
      cfg.invert_select = 2'd0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_BRIGHTNESS: cfg.brightness_gain = val[15:0];
        REG_LIGHTMAP:   cfg.lightmap_gain = val[15:0];
        REG_CONTRAST:   cfg.contrast_gain = val[15:0];
        REG_SATURATION: cfg.saturation_mix = val[15:0];
        REG_MONOCHROME: cfg.monochrome_select = val[1:0];
        REG_INVERT:     cfg.invert_select = val[1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_BRIGHTNESS: return {16'h0, cfg.brightness_gain};
        REG_LIGHTMAP:   return {16'h0, cfg.lightmap_gain};
        REG_CONTRAST:   return {16'h0, cfg.contrast_gain};
        REG_SATURATION: return {16'h0, cfg.saturation_mix};
        REG_MONOCHROME: return {30'h0, cfg.monochrome_select};
        REG_INVERT:     return {30'h0, cfg.invert_select};
        default:        return 32'h0;
      endcase
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: mismatch %s: expected %h actual %h", $time, what, want, got);
    endfunction

    // Gain scaling, hue-keeping clip, contrast, saturation, then the
    // per-class monochrome and inversion steps.
    function pixel_out_t adjust(pixel_in_t p);
      longint t[3];
      longint gain, mx, v, u, d, w, b, m;
      logic [7:0] c[3];
      logic [7:0] ch[3];
      logic [1:0] mask;
      pixel_out_t r;
      c[0] = p.red_in;
      c[1] = p.green_in;
      c[2] = p.blue_in;
      mask = (p.image_class == CLASS_WORLD) ? 2'b01 :
             (p.image_class == CLASS_LIGHTMAP) ? 2'b10 : 2'b00;
      gain = (p.image_class == CLASS_LIGHTMAP) ? longint'(cfg.lightmap_gain)
                                               : longint'(cfg.brightness_gain);
      mx = 0;
      for (int j = 0; j < 3; j++) begin
        t[j] = ((longint'(c[j]) * gain) << FRAC) / (longint'(255) * GAIN_SCALE);
        if (t[j] > mx) mx = t[j];
      end
      if (mx > ONE) begin
        for (int j = 0; j < 3; j++) t[j] = (t[j] * ONE) / mx;
      end
      for (int j = 0; j < 3; j++) begin
        v = HALF * GAIN_SCALE + (t[j] - HALF) * longint'(cfg.contrast_gain);
        if (v < 0) begin
          t[j] = 0;
        end else begin
          u = v >>> GAIN_BITS;
          t[j] = (u > ONE) ? ONE : u;
        end
      end
      d = (longint'(LUMA_R) * t[0] + longint'(LUMA_G) * t[1] + longint'(LUMA_B) * t[2])
          >>> LUMA_SHIFT;
      for (int j = 0; j < 3; j++) begin
        w = d * GAIN_SCALE + (t[j] - d) * longint'(cfg.saturation_mix);
        if (w <= 0) begin
          b = 0;
        end else begin
          b = (w * 255) >>> (GAIN_BITS + FRAC);
          if (b > 255) b = 255;
        end
        ch[j] = b[7:0];
      end
      if ((cfg.monochrome_select & mask) != 2'b00) begin
        m = (longint'(ch[0]) + longint'(ch[1]) + longint'(ch[2])) / 3;
        for (int j = 0; j < 3; j++) ch[j] = m[7:0];
      end
      if ((cfg.invert_select & mask) != 2'b00) begin
        for (int j = 0; j < 3; j++) ch[j] = 8'd255 - ch[j];
      end
      r.red_out = ch[0];
      r.green_out = ch[1];
      r.blue_out = ch[2];
      r.alpha_out = p.alpha_in;
      r.last_pixel_out = p.last_pixel;
      return r;
    endfunction

    function void note_pixel(pixel_in_t p);
      expected_q.push_back(adjust(p));
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (expected_q.size() == 0) begin
        flag("result beat with no pixel pending", 32'h0, 32'(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.red_out !== want.red_out) flag("red_out", want.red_out, got.red_out);
      if (got.green_out !== want.green_out) flag("green_out", want.green_out, got.green_out);
      if (got.blue_out !== want.blue_out) flag("blue_out", want.blue_out, got.blue_out);
      if (got.alpha_out !== want.alpha_out) flag("alpha_out", want.alpha_out, got.alpha_out);
      if (got.last_pixel_out !== want.last_pixel_out)
        flag("last_pixel_out", want.last_pixel_out, got.last_pixel_out);
    endfunction

    function void check_reg(logic [2:0] idx, logic [31:0] got);
      if (got !== reg_value(idx)) flag($sformatf("register %0d readback", idx),
                                       reg_value(idx), got);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  pixel_in_t   pixel_beat;
  logic        done;
  pixel_out_t  result_beat;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pixel_scoreboard sb;
  int idle_cycles;

  pixel_color_adjust #(
    .FRACTION_BITS(FRAC)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .pixel   (pixel_beat),
    .done    (done),
    .result  (result_beat),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Sample both beats on the rising edge; any beat or register access
  // clears the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy) sb.note_pixel(pixel_beat);
      if (done) sb.check_result(result_beat);
      if ((start && !busy) || done || (psel && penable && pready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("FAIL pixel_color_adjust");
    $finish;
  end

  function automatic pixel_in_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] a, logic [1:0] cls, logic last);
    pixel_in_t p;
    p.red_in = r;
    p.green_in = g;
    p.blue_in = b;
    p.alpha_in = a;
    p.image_class = cls;
    p.last_pixel = last;
    return p;
  endfunction

  function automatic logic [7:0] rand_channel();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_in_t rand_pixel();
    int sel;
    logic [1:0] cls;
    sel = $urandom_range(0, 9);
    cls = (sel < 3) ? CLASS_OTHER : (sel < 6) ? CLASS_WORLD :
          (sel < 9) ? CLASS_LIGHTMAP : CLASS_SPARE;
    return make_pixel(rand_channel(), rand_channel(), rand_channel(),
                      8'($urandom), cls, $urandom_range(0, 15) == 0);
  endfunction

  function automatic int rand_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Junk in the upper bits must be dropped by the register.
  function automatic logic [31:0] rand_reg_value(logic [2:0] idx);
    int sel;
    logic [31:0] junk;
    sel = $urandom_range(0, 9);
    junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_0000) : 32'h0;
    if (idx == REG_MONOCHROME || idx == REG_INVERT)
      return junk | ($urandom & 32'h0000_FFFC) | 32'($urandom_range(0, 3));
    case (sel)
      0: return junk;
      1: return junk | 32'h0000_FFFF;
      2: return junk | 32'd4096;
      3, 4, 5, 6: return junk | 32'($urandom_range(2048, 8192));
      default: return junk | 32'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(logic [2:0] idx);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_reg(idx, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all();
    for (int i = REG_BRIGHTNESS; i <= REG_INVERT; i++) reg_read(3'(i));
  endtask

  // Writes every register with either a fixed word or random values.
  task automatic program_regs(bit random_values, logic [31:0] fixed);
    for (int i = REG_BRIGHTNESS; i <= REG_INVERT; i++)
      reg_write(3'(i), random_values ? rand_reg_value(3'(i)) : fixed);
    if ($urandom_range(0, 1) == 0) reg_write(REG_SPARE_A, $urandom);
    read_all();
  endtask

  task automatic send_pixel(pixel_in_t p, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    pixel_beat <= p;
    do @(posedge clk); while (busy);
  endtask

  // Registers change only once every pixel in flight has come back.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random(int n);
    bit burst;
    burst = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) burst = ($urandom_range(0, 3) == 0);
      send_pixel(rand_pixel(), burst ? 0 : rand_gap());
    end
  endtask

  initial begin : main
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    pixel_beat = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values, then extremes of every field and every image class.
    read_all();
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, CLASS_OTHER, 1'b0), 0);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, CLASS_OTHER, 1'b1), 0);
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd128, CLASS_WORLD, 1'b0), 1);
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd1, CLASS_LIGHTMAP, 1'b0), 0);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 8'd254, CLASS_SPARE, 1'b1), 2);
    send_pixel(make_pixel(8'd128, 8'd64, 8'd32, 8'd170, CLASS_WORLD, 1'b0), 0);
    send_pixel(make_pixel(8'd85, 8'd170, 8'd15, 8'd85, CLASS_LIGHTMAP, 1'b1), 0);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, CLASS_SPARE, 1'b0), 0);
    wait_idle();

    // Gain of four forces the hue clip, strong contrast drives dark
    // channels below zero, and the class selects differ per class.
    reg_write(REG_BRIGHTNESS, 32'hA5A5_4000);
    reg_write(REG_LIGHTMAP, 32'd2048);
    reg_write(REG_CONTRAST, 32'd12288);
    reg_write(REG_SATURATION, 32'd0);
    reg_write(REG_MONOCHROME, 32'hFFFF_FFFD);
    reg_write(REG_INVERT, 32'd2);
    reg_write(REG_SPARE_B, 32'hFFFF_FFFF);
    read_all();
    send_pixel(make_pixel(8'd255, 8'd128, 8'd0, 8'd7, CLASS_OTHER, 1'b0), 0);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd9, CLASS_WORLD, 1'b0), 0);
    send_pixel(make_pixel(8'd10, 8'd200, 8'd30, 8'd11, CLASS_LIGHTMAP, 1'b1), 0);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd13, CLASS_LIGHTMAP, 1'b0), 3);
    send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd15, CLASS_SPARE, 1'b0), 0);
    send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 8'd17, CLASS_WORLD, 1'b1), 0);
    send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd19, CLASS_WORLD, 1'b0), 0);
    send_pixel(make_pixel(8'd40, 8'd20, 8'd60, 8'd21, CLASS_OTHER, 1'b1), 0);
    wait_idle();

    // Random pixels with the previous settings, then all-zero, all-ones and random settings.
    run_random(60);
    wait_idle();
    program_regs(1'b0, 32'h0000_0000);
    run_random(60);
    wait_idle();
    program_regs(1'b0, 32'hFFFF_FFFF);
    run_random(60);
    for (int phase = 0; phase < 7; phase++) begin
      wait_idle();
      program_regs(1'b1, 32'h0);
      run_random(60);
    end
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS pixel_color_adjust");
    end else begin
      $display("FAIL pixel_color_adjust");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pca_pkg.sv
rtl/pca_scale.sv
rtl/pca_hue_div.sv
rtl/pca_tone.sv
rtl/pca_post.sv
rtl/pixel_color_adjust.sv
dv/pixel_color_adjust_test.sv
